// ===== design/vector_distance_metric_assert.svh =====
// Assertion macros for the vector distance metric block.
`ifndef VECTOR_DISTANCE_METRIC_ASSERT_SVH
`define VECTOR_DISTANCE_METRIC_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VDM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define VDM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/vdm_pkg.sv =====
`timescale 1ns / 1ps
package vdm_pkg;

	localparam int ACC_W = 48;

	localparam logic [1:0] METRIC_COS = 2'd0;
	localparam logic [1:0] METRIC_EUC = 2'd1;
	localparam logic [1:0] METRIC_IP  = 2'd2;

	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	typedef struct packed {
		logic signed [ACC_W-1:0] dot;
		logic signed [ACC_W-1:0] norm_a;
		logic signed [ACC_W-1:0] norm_b;
		logic signed [ACC_W-1:0] diff_sq;
	} acc_t;

endpackage

// ===== design/vdm_acc.sv =====
`timescale 1ns / 1ps
module vdm_acc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               clear,
	input  logic signed [15:0] a,
	input  logic signed [15:0] b,
	output logic               done,
	output vdm_pkg::acc_t      accs
);
	import vdm_pkg::*;

	logic signed [15:0]      a_q, b_q;
	logic                    busy_q, done_q;
	logic [1:0]              phase_q;
	logic signed [ACC_W-1:0] acc_q [4];
	logic signed [16:0]      d, op_x, op_y;
	logic signed [33:0]      prod;
	logic signed [ACC_W:0]   sum;
	logic signed [ACC_W-1:0] sat;

	assign d = 17'(a_q) - 17'(b_q);

	always_comb begin
		unique case (phase_q)
			2'd0: begin op_x = 17'(a_q); op_y = 17'(b_q); end
			2'd1: begin op_x = 17'(a_q); op_y = 17'(a_q); end
			2'd2: begin op_x = 17'(b_q); op_y = 17'(b_q); end
			default: begin op_x = d; op_y = d; end
		endcase
	end

	assign prod = op_x * op_y;
	assign sum  = (ACC_W+1)'(acc_q[phase_q]) + (ACC_W+1)'(prod);

	always_comb begin
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat = sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
		end else begin
			done_q <= busy_q && !start && (phase_q == 2'd3);
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end else if (busy_q) begin
				acc_q[phase_q] <= sat;
				phase_q        <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end else if (clear) begin
				for (int i = 0; i < 4; i++) acc_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
	end

	assign done         = done_q;
	assign accs.dot     = acc_q[0];
	assign accs.norm_a  = acc_q[1];
	assign accs.norm_b  = acc_q[2];
	assign accs.diff_sq = acc_q[3];

endmodule

// ===== design/vdm_sqrt.sv =====
`timescale 1ns / 1ps
module vdm_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [49:0] radicand,
	output logic        done,
	output logic [24:0] root
);
	logic [49:0] rad_q;
	logic [25:0] rem_q;
	logic [24:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [27:0] rem_sh, trial, rem_sub;

	assign rem_sh  = {rem_q, rad_q[49:48]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 5'd24);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd24) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[47:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sub[25:0];
				root_q <= {root_q[23:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[25:0];
				root_q <= {root_q[23:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = (rem_q > {1'b0, root_q}) ? root_q + 25'd1 : root_q;

endmodule

// ===== design/vdm_div.sv =====
`timescale 1ns / 1ps
module vdm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] numer,
	input  logic [47:0] denom,
	output logic        done,
	output logic [63:0] quot
);
	logic [63:0] num_q, quo_q;
	logic [47:0] den_q, rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [48:0] rem_sh, rem_sub;

	assign rem_sh  = {rem_q, num_q[63]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 6'd63);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sub[47:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[47:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== design/vector_distance_metric.sv =====
// Element pair: one shared multiplier, 4 passes, then ready again.
// Last pair adds, up to result valid and ready again: nothing more for inner product,
// a 25-step root for euclidean, and for cosine two roots, one multiply and a 64-step
// divide, with the divide skipped when a norm is zero.
// One item at a time; the result register frees the next transfer.
// Reset clears accumulators, metric (cosine) and all handshake state.
`timescale 1ns / 1ps
`include "vector_distance_metric_assert.svh"
module vector_distance_metric (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] elem_a,
	input  logic signed [15:0] elem_b,
	input  logic               last_element,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] distance,
	output logic               zero_norm,
	input  logic               metric_we,
	input  logic [1:0]         metric_wdata
);
	import vdm_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ACC  = 8'b0000_0010,
		ST_SQA  = 8'b0000_0100,
		ST_SQB  = 8'b0000_1000,
		ST_MUL  = 8'b0001_0000,
		ST_CHK  = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_RES  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [1:0]         metric_q;
	logic               last_q, sq_start_q, div_start_q;
	logic               out_valid_q, out_z_q, res_z_q;
	logic signed [31:0] out_dist_q, res_dist_q;
	logic [24:0]        sa_q, sb_q;
	logic [47:0]        den_q;
	logic               in_xfer, slot_free, acc_done, sq_done, div_done;
	acc_t               accs;
	logic [49:0]        radicand;
	logic [24:0]        root;
	logic [47:0]        mag;
	logic [63:0]        numer, quot;
	logic [49:0]        ip_val;
	logic [35:0]        ip_sh;
	logic signed [31:0] ip_dist, cos_dist;
	logic [16:0]        qc;
	logic signed [32:0] cosv;
	logic [49:0]        den_full;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	vdm_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.clear  ((state_q == ST_RES) && slot_free),
		.a      (elem_a),
		.b      (elem_b),
		.done   (acc_done),
		.accs   (accs)
	);

	always_comb begin
		if (state_q == ST_SQB) begin
			radicand = {2'b00, accs.norm_b};
		end else if (metric_q == METRIC_EUC) begin
			radicand = {accs.diff_sq, 2'b00};
		end else begin
			radicand = {2'b00, accs.norm_a};
		end
	end

	vdm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start_q),
		.radicand (radicand),
		.done     (sq_done),
		.root     (root)
	);

	assign mag   = accs.dot[ACC_W-1] ? 48'(48'd0 - accs.dot) : accs.dot;
	assign numer = {mag, 16'd0} + {17'd0, den_q[47:1]};

	vdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.numer  (numer),
		.denom  (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	// negated dot, rounded half up at bit 14, saturated
	assign ip_val = 50'd8192 - {{2{accs.dot[ACC_W-1]}}, accs.dot};
	assign ip_sh  = ip_val[49:14];
	always_comb begin
		if (!ip_sh[35] && (ip_sh[34:31] != 4'd0)) begin
			ip_dist = 32'sh7FFF_FFFF;
		end else if (ip_sh[35] && (ip_sh[34:31] != 4'hF)) begin
			ip_dist = 32'sh8000_0000;
		end else begin
			ip_dist = ip_sh[31:0];
		end
	end

	assign qc       = (quot > 64'd65536) ? 17'd65536 : quot[16:0];
	assign cosv     = accs.dot[ACC_W-1] ? 33'sd0 - 33'(qc) : 33'(qc);
	assign cos_dist = 32'(33'(ONE_Q16) - cosv);
	assign den_full = sa_q * sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			metric_q    <= METRIC_COS;
			sq_start_q  <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sq_start_q  <= ((state_q == ST_ACC) && acc_done && last_q && (metric_q != METRIC_IP))
				|| ((state_q == ST_SQA) && sq_done && (metric_q != METRIC_EUC));
			div_start_q <= (state_q == ST_CHK) && (den_q != 48'd0);
			if (metric_we) metric_q <= metric_wdata;
			if ((state_q == ST_RES) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_xfer) state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_done) begin
						if (!last_q) begin
							state_q <= ST_IDLE;
						end else if (metric_q == METRIC_IP) begin
							state_q <= ST_RES;
						end else begin
							state_q <= ST_SQA;
						end
					end
				end
				ST_SQA: begin
					if (sq_done) begin
						if (metric_q == METRIC_EUC) begin
							state_q <= ST_RES;
						end else begin
							state_q <= ST_SQB;
						end
					end
				end
				ST_SQB: if (sq_done) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_CHK;
				ST_CHK: begin
					if (den_q == 48'd0) begin
						state_q <= ST_RES;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: if (div_done) state_q <= ST_RES;
				ST_RES: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) last_q <= last_element;
		if ((state_q == ST_ACC) && acc_done) begin
			res_dist_q <= ip_dist;
			res_z_q    <= 1'b0;
		end
		if ((state_q == ST_SQA) && sq_done) begin
			sa_q       <= root;
			res_dist_q <= 32'(root);
			res_z_q    <= 1'b0;
		end
		if ((state_q == ST_SQB) && sq_done) sb_q <= root;
		if (state_q == ST_MUL) den_q <= den_full[47:0];
		if ((state_q == ST_CHK) && (den_q == 48'd0)) begin
			res_dist_q <= ONE_Q16;
			res_z_q    <= 1'b1;
		end
		if ((state_q == ST_DIV) && div_done) begin
			res_dist_q <= cos_dist;
			res_z_q    <= 1'b0;
		end
		if ((state_q == ST_RES) && slot_free) begin
			out_dist_q <= res_dist_q;
			out_z_q    <= res_z_q;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = out_dist_q;
	assign zero_norm = out_z_q;

	`VDM_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "ready after transfer")
	`VDM_ASSERT_IMP(a_zero_norm_one, out_valid && zero_norm, distance == ONE_Q16, "zero_norm value")
	`VDM_ASSERT_NXT(a_res_load, (state_q == ST_RES) && slot_free,
		out_valid && (state_q == ST_IDLE), "result not loaded")

endmodule
